// ===== sv/kfm_pkg.sv =====
// Shared types and constants for the KMP first-match finder.
// Used by kfm_cell, kfm_seq and kmp_first_match_finder; depends on nothing.
`default_nettype none

package kfm_pkg;

    // Default sizing of the pattern row and of the text position counter.
    localparam int PATTERN_MAX_DEF        = 64;
    localparam int TEXT_POSITION_BITS_DEF = 16;

    // Fixed field widths of the beats.
    localparam int SYM_W       = 8;
    localparam int POS_FIELD_W = 16;

    // Codes of the func field.
    localparam logic FUNC_PATTERN = 1'b0;
    localparam logic FUNC_TEXT    = 1'b1;

    // Input beat.
    typedef struct packed {
        logic             func;
        logic [SYM_W-1:0] symbol;
        logic             last;
    } kfm_in_t;

    // Result beat.
    typedef struct packed {
        logic                   found;
        logic [POS_FIELD_W-1:0] match_start;
        logic [POS_FIELD_W-1:0] match_end;
    } kfm_out_t;

    // What the row of cells does with the match token this cycle.
    typedef enum logic [1:0] {
        ACT_HOLD,
        ACT_ADVANCE,
        ACT_JUMP,
        ACT_HOME
    } kfm_act_t;

    // Command broadcast from the sequencer to every cell.
    typedef struct packed {
        kfm_act_t         act;
        logic [SYM_W-1:0] sym;
        logic             store_wr;
        logic             fb_wr;
    } kfm_cmd_t;

endpackage : kfm_pkg

`default_nettype wire

// ===== sv/kfm_cell.sv =====
// One cell of the pattern row: a pattern byte, the failure link for its
// position and a share of the one-hot match token. Depends on kfm_pkg.
`default_nettype none

module kfm_cell #(
    parameter int PATTERN_MAX = kfm_pkg::PATTERN_MAX_DEF,
    parameter int CELL_INDEX  = 0
) (
    input  wire                                      aclk,
    input  wire                                      aresetn,
    input  kfm_pkg::kfm_cmd_t                        cmd,
    input  wire [((PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1)-1:0] sel_idx,
    input  wire [((PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1)-1:0] fb_val,
    input  wire                                      left_tok,
    output logic                                     tok,
    output logic                                     eq_hit,
    output logic [((PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1)-1:0] fb_out,
    output logic [((PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1)-1:0] idx_out,
    output logic [kfm_pkg::SYM_W-1:0]               byte_out
);

    localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_INDEX);
    localparam logic IS_HEAD = (CELL_INDEX == 0);

    logic [kfm_pkg::SYM_W-1:0] byte_reg;
    logic [IDX_W-1:0]          fb_reg;
    logic                      tok_reg;
    logic                      tok_next;
    logic                      sel_hit;

    assign sel_hit = (sel_idx == MY_IDX);

    // Token movement: step to the right neighbor, jump to a failure target,
    // or return to the head of the row.
    always_comb begin
        case (cmd.act)
            kfm_pkg::ACT_HOLD:    tok_next = tok_reg;
            kfm_pkg::ACT_ADVANCE: tok_next = left_tok;
            kfm_pkg::ACT_JUMP:    tok_next = sel_hit;
            kfm_pkg::ACT_HOME:    tok_next = IS_HEAD;
            default:              tok_next = tok_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg <= IS_HEAD;
        end else begin
            tok_reg <= tok_next;
        end
    end

    // Pattern byte and failure link are written by address broadcast.
    always_ff @(posedge aclk) begin
        if (cmd.store_wr && sel_hit) begin
            byte_reg <= cmd.sym;
        end
        if (cmd.fb_wr && sel_hit) begin
            fb_reg <= fb_val;
        end
    end

    // Outputs are gated so that the row can be OR-combined.
    assign tok      = tok_reg;
    assign eq_hit   = tok_reg && (byte_reg == cmd.sym);
    assign fb_out   = (tok_reg && !IS_HEAD) ? fb_reg : '0;
    assign idx_out  = tok_reg ? MY_IDX : '0;
    assign byte_out = sel_hit ? byte_reg : '0;

endmodule : kfm_cell

`default_nettype wire

// ===== sv/kfm_seq.sv =====
// Sequencer of the KMP finder: beat handshakes, pattern loading, failure
// table build, text stepping and the result register. Depends on kfm_pkg.
`default_nettype none

module kfm_seq #(
    parameter int PATTERN_MAX        = kfm_pkg::PATTERN_MAX_DEF,
    parameter int TEXT_POSITION_BITS = kfm_pkg::TEXT_POSITION_BITS_DEF
) (
    input  wire                                      aclk,
    input  wire                                      aresetn,
    input  wire                                      s_valid,
    output logic                                     s_ready,
    input  kfm_pkg::kfm_in_t                         s_data,
    output logic                                     m_valid,
    input  wire                                      m_ready,
    output kfm_pkg::kfm_out_t                        m_data,
    output kfm_pkg::kfm_cmd_t                        cmd,
    output logic [((PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1)-1:0] sel_idx,
    output logic [((PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1)-1:0] fb_val,
    input  wire                                      g_eq,
    input  wire  [((PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1)-1:0] g_fb,
    input  wire  [((PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1)-1:0] g_idx,
    input  wire  [kfm_pkg::SYM_W-1:0]               g_byte
);

    localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int LEN_W = $clog2(PATTERN_MAX + 1);
    localparam int POS_W = TEXT_POSITION_BITS;
    localparam int OW    = kfm_pkg::POS_FIELD_W;
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(PATTERN_MAX);
    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_FETCH,
        S_BUILD,
        S_WAIT
    } state_t;

    state_t                    state_reg, state_next;
    logic [LEN_W-1:0]          len_reg, len_next;
    logic [LEN_W-1:0]          load_cnt_reg, load_cnt_next;
    logic                      done_reg, done_next;
    logic [POS_W-1:0]          pos_reg, pos_next;
    logic [IDX_W-1:0]          j_reg, j_next;
    logic [kfm_pkg::SYM_W-1:0] sym_reg, sym_next;
    logic                      last_reg, last_next;
    logic                      m_valid_reg, m_valid_next;
    kfm_pkg::kfm_out_t         out_reg, out_next;
    kfm_pkg::kfm_out_t         pend_reg, pend_next;

    logic                      res_valid;
    kfm_pkg::kfm_out_t         res;
    logic                      out_free;
    logic                      step_end;
    logic                      is_match;
    logic [LEN_W-1:0]          new_len;
    logic [LEN_W-1:0]          tok_next_len;
    logic [LEN_W-1:0]          j_plus;
    logic [POS_W-1:0]          pos_inc;
    logic [OW-1:0]             pos_field;

    assign out_free     = !m_valid_reg || m_ready;
    assign pos_inc      = (pos_reg != POS_MAX) ? (pos_reg + POS_W'(1)) : pos_reg;
    assign pos_field    = OW'(pos_reg);
    assign tok_next_len = LEN_W'(g_idx) + LEN_W'(1);
    assign j_plus       = LEN_W'(j_reg) + LEN_W'(1);
    assign new_len      = (load_cnt_reg < LEN_MAX) ? (load_cnt_reg + LEN_W'(1))
                                                   : load_cnt_reg;

    // Next-state logic for the whole sequencer.
    always_comb begin
        state_next    = state_reg;
        len_next      = len_reg;
        load_cnt_next = load_cnt_reg;
        done_next     = done_reg;
        pos_next      = pos_reg;
        j_next        = j_reg;
        sym_next      = sym_reg;
        last_next     = last_reg;
        pend_next     = pend_reg;
        out_next      = out_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        cmd.act       = kfm_pkg::ACT_HOLD;
        cmd.sym       = sym_reg;
        cmd.store_wr  = 1'b0;
        cmd.fb_wr     = 1'b0;
        sel_idx       = j_reg;
        fb_val        = '0;
        res_valid     = 1'b0;
        res           = '0;
        step_end      = 1'b0;
        is_match      = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    sym_next  = s_data.symbol;
                    last_next = s_data.last;
                    if (s_data.func == kfm_pkg::FUNC_PATTERN) begin
                        // Store the byte unless the row is already full.
                        if (load_cnt_reg < LEN_MAX) begin
                            cmd.store_wr  = 1'b1;
                            cmd.sym       = s_data.symbol;
                            sel_idx       = load_cnt_reg[IDX_W-1:0];
                            load_cnt_next = new_len;
                        end
                        // Final pattern byte commits the length and re-arms.
                        if (s_data.last) begin
                            len_next      = new_len;
                            load_cnt_next = '0;
                            cmd.act       = kfm_pkg::ACT_HOME;
                            pos_next      = '0;
                            done_next     = 1'b0;
                            j_next        = IDX_W'(1);
                            if (new_len > LEN_W'(1)) begin
                                state_next = S_FETCH;
                            end
                        end
                    end else if (done_reg) begin
                        // Text after a match is skipped until its end.
                        if (s_data.last) begin
                            cmd.act   = kfm_pkg::ACT_HOME;
                            pos_next  = '0;
                            done_next = 1'b0;
                        end
                    end else if (len_reg == '0) begin
                        // An empty pattern never matches.
                        pos_next = pos_inc;
                        if (s_data.last) begin
                            res_valid = 1'b1;
                            cmd.act   = kfm_pkg::ACT_HOME;
                            pos_next  = '0;
                        end
                    end else begin
                        state_next = S_SEARCH;
                    end
                end
            end

            S_SEARCH: begin
                // One comparison or one failure jump per cycle.
                if (g_eq) begin
                    if (tok_next_len == len_reg) begin
                        is_match  = 1'b1;
                        res_valid = 1'b1;
                        res.found = 1'b1;
                        res.match_start = pos_field - OW'(len_reg) + OW'(1);
                        res.match_end   = pos_field;
                        cmd.act   = kfm_pkg::ACT_HOME;
                        done_next = 1'b1;
                    end else begin
                        cmd.act = kfm_pkg::ACT_ADVANCE;
                    end
                    step_end = 1'b1;
                end else if (g_idx == '0) begin
                    step_end = 1'b1;
                end else begin
                    cmd.act = kfm_pkg::ACT_JUMP;
                    sel_idx = g_fb;
                end
                if (step_end) begin
                    pos_next   = pos_inc;
                    state_next = S_IDLE;
                    if (last_reg) begin
                        if (!is_match) begin
                            res_valid = 1'b1;
                        end
                        cmd.act   = kfm_pkg::ACT_HOME;
                        pos_next  = '0;
                        done_next = 1'b0;
                    end
                end
            end

            S_FETCH: begin
                // Read pattern byte j; the first pass also seeds link one.
                sel_idx   = j_reg;
                cmd.fb_wr = (j_reg == IDX_W'(1));
                fb_val    = '0;
                sym_next  = g_byte;
                state_next = S_BUILD;
            end

            S_BUILD: begin
                // Run the matcher over the pattern itself to get its links.
                sel_idx = j_reg + IDX_W'(1);
                if (g_eq) begin
                    cmd.act  = kfm_pkg::ACT_ADVANCE;
                    fb_val   = g_idx + IDX_W'(1);
                    step_end = 1'b1;
                end else if (g_idx == '0) begin
                    fb_val   = '0;
                    step_end = 1'b1;
                end else begin
                    cmd.act = kfm_pkg::ACT_JUMP;
                    sel_idx = g_fb;
                end
                if (step_end) begin
                    cmd.fb_wr = (j_plus < LEN_MAX);
                    if (j_plus == len_reg) begin
                        cmd.act    = kfm_pkg::ACT_HOME;
                        state_next = S_IDLE;
                    end else begin
                        j_next     = j_reg + IDX_W'(1);
                        state_next = S_FETCH;
                    end
                end
            end

            S_WAIT: begin
                if (out_free) begin
                    out_next     = pend_reg;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase

        // A new result goes to the output register, or waits if it is full.
        if (res_valid) begin
            if (out_free) begin
                out_next     = res;
                m_valid_next = 1'b1;
            end else begin
                pend_next  = res;
                state_next = S_WAIT;
            end
        end
    end

    // State and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            len_reg      <= '0;
            load_cnt_reg <= '0;
            done_reg     <= 1'b0;
            pos_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            len_reg      <= len_next;
            load_cnt_reg <= load_cnt_next;
            done_reg     <= done_next;
            pos_reg      <= pos_next;
            m_valid_reg  <= m_valid_next;
        end
        j_reg    <= j_next;
        sym_reg  <= sym_next;
        last_reg <= last_next;
        out_reg  <= out_next;
        pend_reg <= pend_next;
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule : kfm_seq

`default_nettype wire

// ===== sv/kmp_first_match_finder.sv =====
// Top level of the KMP first-match finder: a row of pattern cells and the
// sequencer that drives it. Depends on kfm_pkg, kfm_cell and kfm_seq.
//
// Usage: s_ beats carry pattern bytes (func = 0) or text bytes (func = 1),
// with last marking the end of a pattern or of a text. The m_ channel gives
// at most one beat per text: the first match with its start and end text
// positions, or a not-found beat when the text ends without a match.
// A pattern byte is accepted while idle. The last pattern byte then starts
// the failure link build: per pattern position a fetch step, then
// comparisons or failure jumps in the cell row until the link is written.
// A text byte is accepted while idle and stepped through the cell row one
// comparison or failure jump at a time; no new beat is taken meanwhile, and
// KMP keeps that near one step per byte on average. The final step puts the
// result beat in the output register, or a pending one while it is full.
// The match token moves one cell per cycle, and that loop sets the rate.
// Reset empties the pattern and re-arms the matcher; pattern bytes read
// back only after they are written. A stalled receiver holds the result
// register; the block keeps taking beats and only waits when a second
// result is ready before the first has been taken.
`default_nettype none

module kmp_first_match_finder #(
    parameter int PATTERN_MAX        = kfm_pkg::PATTERN_MAX_DEF,
    parameter int TEXT_POSITION_BITS = kfm_pkg::TEXT_POSITION_BITS_DEF
) (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               s_valid,
    output logic              s_ready,
    input  kfm_pkg::kfm_in_t  s_data,
    output logic              m_valid,
    input  wire               m_ready,
    output kfm_pkg::kfm_out_t m_data
);

    localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

    kfm_pkg::kfm_cmd_t         cmd;
    logic [IDX_W-1:0]          sel_idx;
    logic [IDX_W-1:0]          fb_val;
    logic [PATTERN_MAX-1:0]    tok_vec;
    logic [PATTERN_MAX-1:0]    eq_vec;
    logic [IDX_W-1:0]          fb_vec   [PATTERN_MAX];
    logic [IDX_W-1:0]          idx_vec  [PATTERN_MAX];
    logic [kfm_pkg::SYM_W-1:0] byte_vec [PATTERN_MAX];
    logic                      g_eq;
    logic [IDX_W-1:0]          g_fb;
    logic [IDX_W-1:0]          g_idx;
    logic [kfm_pkg::SYM_W-1:0] g_byte;

    // Row of cells; each hands its token to the right neighbor on a step.
    for (genvar gi = 0; gi < PATTERN_MAX; gi++) begin : g_cell
        logic left_tok;
        if (gi == 0) begin : g_head
            assign left_tok = 1'b0;
        end else begin : g_body
            assign left_tok = tok_vec[gi-1];
        end
        kfm_cell #(
            .PATTERN_MAX (PATTERN_MAX),
            .CELL_INDEX  (gi)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cmd      (cmd),
            .sel_idx  (sel_idx),
            .fb_val   (fb_val),
            .left_tok (left_tok),
            .tok      (tok_vec[gi]),
            .eq_hit   (eq_vec[gi]),
            .fb_out   (fb_vec[gi]),
            .idx_out  (idx_vec[gi]),
            .byte_out (byte_vec[gi])
        );
    end

    // Cell outputs are gated, so the row combines by OR.
    always_comb begin
        g_fb   = '0;
        g_idx  = '0;
        g_byte = '0;
        for (int i = 0; i < PATTERN_MAX; i++) begin
            g_fb   = g_fb | fb_vec[i];
            g_idx  = g_idx | idx_vec[i];
            g_byte = g_byte | byte_vec[i];
        end
    end

    assign g_eq = |eq_vec;

    kfm_seq #(
        .PATTERN_MAX        (PATTERN_MAX),
        .TEXT_POSITION_BITS (TEXT_POSITION_BITS)
    ) u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .cmd     (cmd),
        .sel_idx (sel_idx),
        .fb_val  (fb_val),
        .g_eq    (g_eq),
        .g_fb    (g_fb),
        .g_idx   (g_idx),
        .g_byte  (g_byte)
    );

endmodule : kmp_first_match_finder

`default_nettype wire
